/* rtl/slli_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slli_pkg: shared types and constants of the light level interpolator
// Transaction structs, mode codes, register indexes and divider interface.
// ----------------------------------------------------------------------------
package slli_pkg;

  localparam int LEVEL_W       = 12;
  localparam int MIN_W         = 11;
  localparam int TIME_W        = 27;
  localparam int QUOT_W        = 12;
  localparam int NUM_W         = QUOT_W + TIME_W;
  localparam int DIV_CNT_W     = 4;
  localparam int MS_PER_MINUTE = 60 * 1000;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_EN = 1'd1;

  typedef enum logic [1:0] {
    MODE_WR_TIME  = 2'd0,
    MODE_WR_LEVEL = 2'd1,
    MODE_WR_OVR   = 2'd2,
    MODE_TICK     = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [3:0]        point_index;
    logic [2:0]        channel;
    logic [11:0]       value;
    logic [TIME_W-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         out_channel;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OVR,
    ST_SRCH_RD,
    ST_SRCH_MUL,
    ST_SRCH_CMP,
    ST_SETUP,
    ST_CH_RD,
    ST_CH_DIFF,
    ST_CH_MUL,
    ST_CH_START,
    ST_CH_DIV,
    ST_CH_OUT
  } state_t;

endpackage
`default_nettype wire

/* rtl/slli_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slli_divider: restoring divider, one quotient bit per cycle
// Numerator is known to be below den << QUOT_W, so QUOT_W steps suffice.
// ----------------------------------------------------------------------------
module slli_divider (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire slli_pkg::div_req_t  req,
  output slli_pkg::div_rsp_t       rsp
);

  logic [slli_pkg::NUM_W-1:0]     rem;
  logic [slli_pkg::NUM_W-1:0]     dsh;
  logic [slli_pkg::QUOT_W-1:0]    quot;
  logic [slli_pkg::DIV_CNT_W-1:0] cnt;
  logic                           run;
  logic                           done;
  logic                           fits;

  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == slli_pkg::DIV_CNT_W'(1));
      if (req.start) begin
        run <= 1'b1;
        cnt <= slli_pkg::DIV_CNT_W'(slli_pkg::QUOT_W);
      end else if (run) begin
        cnt <= cnt - slli_pkg::DIV_CNT_W'(1);
        if (cnt == slli_pkg::DIV_CNT_W'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num;
      dsh  <= slli_pkg::NUM_W'(req.den) << (slli_pkg::QUOT_W - 1);
      quot <= '0;
    end else if (run) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quot <= {quot[slli_pkg::QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule
`default_nettype wire

/* rtl/scheduled_light_level_interpolator_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Writes complete at acceptance. An override tick gives one result per cycle,
//   CHANNELS results starting the cycle after acceptance. A schedule tick reads each point
//   time, converts it (minute-to-ms multiply) and compares it, runs a setup step, then per
//   channel reads levels, subtracts, multiplies and divides in the 12-step shared divider.
// Throughput: one transaction at a time; busy stays high until the last result is out.
// Reset (rst, synchronous): control regs cleared, override levels zero; receiver cannot stall.
// ----------------------------------------------------------------------------
// scheduled_light_level_interpolator_core: schedule-based PWM level interpolator
// Stores point times and levels. A tick emits the override levels, or searches the schedule
// and emits a linearly interpolated level per channel through a shared divider.
// ----------------------------------------------------------------------------
module scheduled_light_level_interpolator_core #(
  parameter int MAX_POINTS = 16,
  parameter int CHANNELS   = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // command channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire slli_pkg::cmd_t                      cmd,
  // result channel, one-cycle strobe
  output logic                                     strobe,
  output slli_pkg::result_t                        result,
  // configuration write port
  input  wire logic                                cfg_wr_en,
  input  wire logic [slli_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [slli_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Index widths derived from the parameters.
  localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;  // point address
  localparam int CW  = $clog2(MAX_POINTS + 1);                      // point counter
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;      // channel counter
  localparam int LWR = $clog2(MAX_POINTS * CHANNELS);
  localparam int LW  = (LWR > 0) ? LWR : 1;                         // level address

  localparam int LVL_W = slli_pkg::LEVEL_W;
  localparam int TW    = slli_pkg::TIME_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [4:0] point_count;
  logic       override_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      override_en <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        slli_pkg::CFG_POINT_COUNT: point_count <= cfg_data;
        slli_pkg::CFG_OVERRIDE_EN: override_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and working registers
  // --------------------------------------------------------------------------
  slli_pkg::state_t state, state_next;

  logic                        accept;
  logic [CW-1:0]               n_eff;     // clamped point count at accept time
  logic [CW-1:0]               n_q;
  logic [CW-1:0]               p;         // search index / end point
  logic [CW-1:0]               p_inc;
  logic [CW-1:0]               prev_idx;  // start point
  logic [CHW-1:0]              ch;
  logic                        ch_last;
  logic [TW-1:0]               now_q;
  logic [slli_pkg::MIN_W-1:0]  time_q;    // point time read back, minutes
  logic [TW-1:0]               t_ms;      // point time in ms
  logic [TW-1:0]               prev_ms;   // time of previous examined point
  logic [TW-1:0]               den_ms;    // t1 - t0
  logic [TW-1:0]               e_ms;      // now - t0
  logic                        den_zero;
  logic                        found;
  logic [LVL_W-1:0]            a_q;       // level at start point
  logic [LVL_W-1:0]            b_q;       // level at end point
  logic [LVL_W-1:0]            absd;
  logic                        neg;
  logic [LVL_W:0]              diff;
  logic [LVL_W:0]              interp;
  logic [slli_pkg::NUM_W-1:0]  prod;
  logic [LW-1:0]               lvl_addr_a;
  logic [LW-1:0]               lvl_addr_b;

  slli_pkg::div_req_t div_req;
  slli_pkg::div_rsp_t div_rsp;

  // Storage
  logic [slli_pkg::MIN_W-1:0]  point_time     [MAX_POINTS];
  logic [LVL_W-1:0]            point_level    [MAX_POINTS * CHANNELS];
  logic [LVL_W-1:0]            override_level [CHANNELS];

  assign accept  = start && !busy;
  assign n_eff   = (int'(point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);
  assign p_inc   = p + CW'(1);
  assign ch_last = (ch == CHW'(CHANNELS - 1));
  assign found   = (t_ms > now_q);

  assign lvl_addr_a = LW'(int'(prev_idx) * CHANNELS + int'(ch));
  assign lvl_addr_b = LW'(int'(p) * CHANNELS + int'(ch));

  // level difference, sign and magnitude
  assign diff = {1'b0, b_q} - {1'b0, a_q};

  // start level moved toward the target by the truncated quotient
  assign interp = neg ? ({1'b0, a_q} - {1'b0, div_rsp.quot})
                      : ({1'b0, a_q} + {1'b0, div_rsp.quot});

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      slli_pkg::ST_IDLE: begin
        if (accept && (cmd.mode == slli_pkg::MODE_TICK)) begin
          if (override_en) begin
            state_next = slli_pkg::ST_OVR;
          end else if (n_eff != '0) begin
            state_next = slli_pkg::ST_SRCH_RD;
          end
        end
      end
      slli_pkg::ST_OVR: begin
        if (ch_last) begin
          state_next = slli_pkg::ST_IDLE;
        end
      end
      slli_pkg::ST_SRCH_RD:  state_next = slli_pkg::ST_SRCH_MUL;
      slli_pkg::ST_SRCH_MUL: state_next = slli_pkg::ST_SRCH_CMP;
      slli_pkg::ST_SRCH_CMP: begin
        if (found) begin
          state_next = slli_pkg::ST_SETUP;
        end else if (p_inc >= n_q) begin
          // no point after now: tick is silent
          state_next = slli_pkg::ST_IDLE;
        end else begin
          state_next = slli_pkg::ST_SRCH_RD;
        end
      end
      slli_pkg::ST_SETUP:    state_next = slli_pkg::ST_CH_RD;
      slli_pkg::ST_CH_RD:    state_next = slli_pkg::ST_CH_DIFF;
      slli_pkg::ST_CH_DIFF:  state_next = slli_pkg::ST_CH_MUL;
      slli_pkg::ST_CH_MUL:   state_next = slli_pkg::ST_CH_START;
      slli_pkg::ST_CH_START: state_next = slli_pkg::ST_CH_DIV;
      slli_pkg::ST_CH_DIV: begin
        if (div_rsp.done) begin
          state_next = slli_pkg::ST_CH_OUT;
        end
      end
      slli_pkg::ST_CH_OUT: begin
        state_next = ch_last ? slli_pkg::ST_IDLE : slli_pkg::ST_CH_RD;
      end
      default: state_next = slli_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slli_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  always_comb begin
    busy          = (state != slli_pkg::ST_IDLE);
    strobe        = 1'b0;
    result        = '0;
    div_req.start = 1'b0;
    div_req.num   = prod;
    div_req.den   = den_ms;
    case (state)
      slli_pkg::ST_OVR: begin
        strobe             = 1'b1;
        result.out_channel = 3'(ch);
        result.level       = override_level[ch];
        result.last        = ch_last;
      end
      slli_pkg::ST_CH_START: begin
        div_req.start = 1'b1;
      end
      slli_pkg::ST_CH_OUT: begin
        strobe             = 1'b1;
        result.out_channel = 3'(ch);
        result.level       = den_zero ? b_q : interp[LVL_W-1:0];
        result.last        = ch_last;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Counters (control)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      p  <= '0;
      ch <= '0;
    end else begin
      case (state)
        slli_pkg::ST_IDLE: begin
          p  <= '0;
          ch <= '0;
        end
        slli_pkg::ST_OVR:      ch <= ch + CHW'(1);
        slli_pkg::ST_SRCH_CMP: if (!found) p <= p_inc;
        slli_pkg::ST_CH_OUT:   ch <= ch + CHW'(1);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      slli_pkg::ST_IDLE: begin
        now_q <= cmd.now_ms;
        n_q   <= n_eff;
      end
      slli_pkg::ST_SRCH_MUL: begin
        t_ms <= TW'(time_q) * TW'(slli_pkg::MS_PER_MINUTE);
      end
      slli_pkg::ST_SRCH_CMP: begin
        // only points at or before now become the ramp start
        if (!found) begin
          prev_ms <= t_ms;
        end
      end
      slli_pkg::ST_SETUP: begin
        // before the first point the ramp starts at midnight from the last point
        if (p == '0) begin
          prev_idx <= n_q - CW'(1);
          den_ms   <= t_ms;
          e_ms     <= now_q;
          den_zero <= (t_ms == '0);
        end else begin
          prev_idx <= p - CW'(1);
          den_ms   <= t_ms - prev_ms;
          e_ms     <= now_q - prev_ms;
          den_zero <= (t_ms == prev_ms);
        end
      end
      slli_pkg::ST_CH_DIFF: begin
        neg  <= diff[LVL_W];
        absd <= diff[LVL_W] ? LVL_W'(-diff) : diff[LVL_W-1:0];
      end
      slli_pkg::ST_CH_MUL: begin
        prod <= slli_pkg::NUM_W'(absd) * slli_pkg::NUM_W'(e_ms);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Schedule memories: one write port, registered reads
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept && (cmd.mode == slli_pkg::MODE_WR_TIME) && (int'(cmd.point_index) < MAX_POINTS))
    begin
      point_time[PW'(cmd.point_index)] <= cmd.value[slli_pkg::MIN_W-1:0];
    end
    if (state == slli_pkg::ST_SRCH_RD) begin
      time_q <= point_time[p[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (cmd.mode == slli_pkg::MODE_WR_LEVEL) &&
        (int'(cmd.point_index) < MAX_POINTS) && (int'(cmd.channel) < CHANNELS)) begin
      point_level[LW'(int'(cmd.point_index) * CHANNELS + int'(cmd.channel))] <= cmd.value;
    end
    if (state == slli_pkg::ST_CH_RD) begin
      a_q <= point_level[lvl_addr_a];
      b_q <= point_level[lvl_addr_b];
    end
  end

  // Override levels live in flops and reset to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        override_level[i] <= '0;
      end
    end else if (accept && (cmd.mode == slli_pkg::MODE_WR_OVR) &&
                 (int'(cmd.channel) < CHANNELS)) begin
      override_level[CHW'(cmd.channel)] <= cmd.value;
    end
  end

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  slli_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

`ifndef SYNTHESIS
  // the final result of a run returns the block to idle
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !busy)
    else $error("busy still high after last result");

  // results are never produced in the cycle a new transaction is taken
  a_no_strobe_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> !strobe)
    else $error("result strobe while accepting a transaction");

  // divider is only started when it has no division in flight
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> !div_rsp.done)
    else $error("divider done right after start");

  // a schedule result only appears once the divider has finished
  a_out_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == slli_pkg::ST_CH_OUT) |-> $past(div_rsp.done))
    else $error("interpolated result without divider completion");
`endif

endmodule
`default_nettype wire
